// ----- src/stp_pkg.sv -----
// shared types and constants for the software timer pool
// used by software_timer_pool_top and the dv files
`default_nettype none
package stp_pkg;
  localparam int unsigned POOL_SLOTS_DEF = 64;
  localparam int unsigned MAX_FIRES_DEF  = 10;
  localparam logic [31:0] HORIZON_RESET  = 32'd1000;

  typedef enum logic [2:0] {
    ACT_ADD    = 3'd0,
    ACT_CANCEL = 3'd1,
    ACT_REMOVE = 3'd2,
    ACT_TICK   = 3'd3,
    ACT_EXTEND = 3'd4,
    ACT_SET    = 3'd5
  } action_t;

  typedef enum logic [2:0] {
    KIND_ADDED = 3'd0,
    KIND_FULL  = 3'd1,
    KIND_FIRED = 3'd2,
    KIND_DONE  = 3'd3,
    KIND_ACK   = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_ADD_LINK,
    ST_ADD_ARM,
    ST_SLOT_RMW,
    ST_REL_PREV,
    ST_REL_NEXT,
    ST_REL_FREE,
    ST_WALK_READ,
    ST_WALK_EVAL,
    ST_WALK_STORE,
    ST_EMIT
  } state_t;
endpackage
`default_nettype wire

// ----- src/stp_slot_mem.sv -----
// per-slot storage: deadline, interval and flag memories plus link memories
// depends on stp_pkg for nothing beyond widths handed in as parameters
`default_nettype none
module stp_slot_mem #(
  parameter int unsigned SLOTS = 64,
  parameter int unsigned AW = 6
) (
  input  wire logic          clk,
  input  wire logic [AW-1:0] addr,
  input  wire logic          we_dl,
  input  wire logic [63:0]   wdata_dl,
  input  wire logic          we_iv,
  input  wire logic [63:0]   wdata_iv,
  input  wire logic          we_fl,
  input  wire logic [2:0]    wdata_fl,
  input  wire logic          we_nx,
  input  wire logic [AW:0]   wdata_nx,
  input  wire logic          we_pv,
  input  wire logic [AW:0]   wdata_pv,
  output logic      [63:0]   rd_dl,
  output logic      [63:0]   rd_iv,
  output logic      [2:0]    rd_fl,
  output logic      [AW:0]   rd_nx,
  output logic      [AW:0]   rd_pv
);
  logic [63:0] dl_mem [SLOTS];
  logic [63:0] iv_mem [SLOTS];
  // flags: {allocated, active, repeat}
  logic [2:0]  fl_mem [SLOTS];
  logic [AW:0] nx_mem [SLOTS];
  logic [AW:0] pv_mem [SLOTS];

  // one write port and one registered read per array
  always_ff @(posedge clk) begin
    if (we_dl) dl_mem[addr] <= wdata_dl;
    if (we_iv) iv_mem[addr] <= wdata_iv;
    if (we_fl) fl_mem[addr] <= wdata_fl;
    if (we_nx) nx_mem[addr] <= wdata_nx;
    if (we_pv) pv_mem[addr] <= wdata_pv;
    rd_dl <= dl_mem[addr];
    rd_iv <= iv_mem[addr];
    rd_fl <= fl_mem[addr];
    rd_nx <= nx_mem[addr];
    rd_pv <= pv_mem[addr];
  end
endmodule
`default_nettype wire

// ----- src/stp_alu.sv -----
// shared 64-bit add and unsigned compare unit used by the sequencer steps
// no package dependency
`default_nettype none
module stp_alu (
  input  wire logic [63:0] a,
  input  wire logic [63:0] b,
  input  wire logic [63:0] c,
  output logic      [63:0] sum,
  output logic             c_le_a,
  output logic             sum_lt_c
);
  // sum = a + b, compare c <= a and sum < c
  assign sum      = a + b;
  assign c_le_a   = (c <= a);
  assign sum_lt_c = (sum < c);
endmodule
`default_nettype wire

// ----- src/software_timer_pool_top.sv -----
// top level of the software timer pool: sequencer, registers and output stage
// depends on stp_pkg, stp_slot_mem and stp_alu
//
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready  | action now_ms amount_ms repeat_req slot
// out     | output    | out_valid / out_ready| kind slot_res next_deadline fire_count last
// cfg     | input     | cfg_we               | cfg_data (horizon_ms)
//
// after reset a clearing pass over all POOL_SLOTS slots builds the free list; not ready meanwhile
// after acceptance: full, set and acknowledge go from dispatch straight to emit; cancel and extend
// add a slot read-modify-write; add links and arms the slot; remove of a live slot also releases it
// a tick reads and evaluates each visited slot, then stores a kept or re-armed one or releases a freed one;
// the single port of the slot memory keeps these steps apart
// each result waits in the output register; the sequencer stalls while it is full and not taken
`default_nettype none
module software_timer_pool_top #(
  parameter int unsigned POOL_SLOTS = stp_pkg::POOL_SLOTS_DEF,
  parameter int unsigned MAX_FIRES  = stp_pkg::MAX_FIRES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  action,
  input  wire logic [63:0] now_ms,
  input  wire logic [63:0] amount_ms,
  input  wire logic        repeat_req,
  input  wire logic [5:0]  slot,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       kind,
  output logic [5:0]       slot_res,
  output logic [63:0]      next_deadline,
  output logic [3:0]       fire_count,
  output logic             last,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data
);
  localparam int unsigned AW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int unsigned FW = $clog2(MAX_FIRES + 1);
  localparam logic [AW:0] NULL_LINK = (AW+1)'(POOL_SLOTS);

  stp_pkg::state_t state, state_next;

  logic [31:0] horizon;
  logic [2:0]  act;
  logic [63:0] now_r, amt_r;
  logic        rep_r;
  logic [5:0]  slot_r;
  logic [AW-1:0] tgt_addr;
  logic [AW:0] free_head, free_head_next;
  logic [AW:0] active_head, active_head_next;
  logic [AW:0] cur, cur_next;
  logic [AW:0] nxt, nxt_next;
  logic [AW:0] rp, rp_next, rn, rn_next;
  logic [63:0] mix, mix_next;
  logic [FW-1:0] fires, fires_next;
  logic [AW:0] guard, guard_next;
  logic [AW:0] clr, clr_next;
  logic        hit, hit_next;
  logic        walk_more;

  // output register
  logic        ov;
  logic [2:0]  o_kind;
  logic [5:0]  o_slot;
  logic [63:0] o_nd;
  logic [3:0]  o_fc;
  logic        o_last;
  logic        emit;
  logic [2:0]  e_kind;
  logic [5:0]  e_slot;
  logic [63:0] e_nd;
  logic [3:0]  e_fc;
  logic        e_last;

  // memory port
  logic [AW-1:0] maddr;
  logic we_dl, we_iv, we_fl, we_nx, we_pv;
  logic [63:0] w_dl, w_iv;
  logic [2:0]  w_fl;
  logic [AW:0] w_nx, w_pv;
  logic [63:0] r_dl, r_iv;
  logic [2:0]  r_fl;
  logic [AW:0] r_nx, r_pv;

  // alu
  logic [63:0] alu_a, alu_b, alu_c, alu_sum;
  logic        alu_le, alu_lt;

  stp_slot_mem #(.SLOTS(POOL_SLOTS), .AW(AW)) u_mem (
    .clk(clk), .addr(maddr),
    .we_dl(we_dl), .wdata_dl(w_dl), .we_iv(we_iv), .wdata_iv(w_iv),
    .we_fl(we_fl), .wdata_fl(w_fl), .we_nx(we_nx), .wdata_nx(w_nx),
    .we_pv(we_pv), .wdata_pv(w_pv),
    .rd_dl(r_dl), .rd_iv(r_iv), .rd_fl(r_fl), .rd_nx(r_nx), .rd_pv(r_pv)
  );

  stp_alu u_alu (
    .a(alu_a), .b(alu_b), .c(alu_c),
    .sum(alu_sum), .c_le_a(alu_le), .sum_lt_c(alu_lt)
  );

  logic in_fire, out_free, tgt_ok;
  assign in_ready  = (state == stp_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !ov || out_ready;
  assign out_valid = ov;
  assign kind = o_kind;
  assign slot_res = o_slot;
  assign next_deadline = o_nd;
  assign fire_count = o_fc;
  assign last = o_last;
  assign tgt_ok = ({26'd0, slot_r} < POOL_SLOTS);
  assign tgt_addr = AW'(slot_r);
  // the walk goes on while slots remain, the fire limit is not reached and the guard allows
  assign walk_more = (nxt != NULL_LINK) && (fires < FW'(MAX_FIRES)) && (guard < NULL_LINK);

  // next-state logic
  always_comb begin
    state_next = state;
    case (state)
      stp_pkg::ST_CLEAR:
        if (clr == NULL_LINK - 1'b1) state_next = stp_pkg::ST_IDLE;
      stp_pkg::ST_IDLE:
        if (in_fire) state_next = stp_pkg::ST_DISPATCH;
      stp_pkg::ST_DISPATCH: begin
        if (act == stp_pkg::ACT_ADD) begin
          state_next = (free_head == NULL_LINK) ? stp_pkg::ST_EMIT : stp_pkg::ST_ADD_LINK;
        end else if (act == stp_pkg::ACT_TICK) begin
          state_next = (active_head == NULL_LINK) ? stp_pkg::ST_EMIT : stp_pkg::ST_WALK_READ;
        end else if (tgt_ok && act inside {stp_pkg::ACT_CANCEL, stp_pkg::ACT_REMOVE,
                                           stp_pkg::ACT_EXTEND}) begin
          state_next = stp_pkg::ST_SLOT_RMW;
        end else begin
          state_next = stp_pkg::ST_EMIT;
        end
      end
      stp_pkg::ST_ADD_LINK: state_next = stp_pkg::ST_ADD_ARM;
      stp_pkg::ST_ADD_ARM:  state_next = stp_pkg::ST_EMIT;
      stp_pkg::ST_SLOT_RMW:
        state_next = (act == stp_pkg::ACT_REMOVE && r_fl[2]) ? stp_pkg::ST_REL_PREV
                                                              : stp_pkg::ST_EMIT;
      stp_pkg::ST_REL_PREV: state_next = stp_pkg::ST_REL_NEXT;
      stp_pkg::ST_REL_NEXT: state_next = stp_pkg::ST_REL_FREE;
      stp_pkg::ST_REL_FREE: begin
        if (act == stp_pkg::ACT_TICK && walk_more) state_next = stp_pkg::ST_WALK_READ;
        else state_next = stp_pkg::ST_EMIT;
      end
      stp_pkg::ST_WALK_READ: state_next = stp_pkg::ST_WALK_EVAL;
      stp_pkg::ST_WALK_EVAL: begin
        if (!r_fl[1]) state_next = stp_pkg::ST_REL_PREV;
        else if (alu_le) begin
          if (out_free) state_next = r_fl[0] ? stp_pkg::ST_WALK_STORE : stp_pkg::ST_REL_PREV;
        end else state_next = stp_pkg::ST_WALK_STORE;
      end
      stp_pkg::ST_WALK_STORE:
        state_next = walk_more ? stp_pkg::ST_WALK_READ : stp_pkg::ST_EMIT;
      stp_pkg::ST_EMIT: if (out_free) state_next = stp_pkg::ST_IDLE;
      default: state_next = stp_pkg::ST_IDLE;
    endcase
  end

  // datapath and output logic
  always_comb begin
    free_head_next = free_head; active_head_next = active_head;
    cur_next = cur; nxt_next = nxt; rp_next = rp; rn_next = rn;
    mix_next = mix; fires_next = fires; guard_next = guard; clr_next = clr;
    hit_next = hit;
    maddr = cur[AW-1:0];
    we_dl = 1'b0; we_iv = 1'b0; we_fl = 1'b0; we_nx = 1'b0; we_pv = 1'b0;
    w_dl = '0; w_iv = '0; w_fl = '0; w_nx = '0; w_pv = '0;
    alu_a = now_r; alu_b = amt_r; alu_c = r_dl;
    emit = 1'b0; e_kind = stp_pkg::KIND_ACK; e_slot = '0; e_nd = '0; e_fc = '0;
    e_last = 1'b1;
    case (state)
      stp_pkg::ST_CLEAR: begin
        // build the free list and clear every slot
        maddr = clr[AW-1:0];
        we_dl = 1'b1; we_iv = 1'b1; we_fl = 1'b1;
        we_nx = 1'b1; w_nx = clr + 1'b1;
        we_pv = 1'b1; w_pv = (clr == '0) ? NULL_LINK : clr - 1'b1;
        clr_next = clr + 1'b1;
      end
      stp_pkg::ST_DISPATCH: begin
        if (act == stp_pkg::ACT_ADD) begin
          cur_next = free_head;
          maddr = free_head[AW-1:0];
        end else if (act == stp_pkg::ACT_TICK) begin
          cur_next = active_head;
          maddr = active_head[AW-1:0];
          alu_b = {32'd0, horizon};
          mix_next = alu_sum;
          fires_next = '0; guard_next = '0;
        end else begin
          cur_next = (AW+1)'(slot_r);
          maddr = tgt_addr;
          if (act == stp_pkg::ACT_SET && tgt_ok) begin
            we_dl = 1'b1; w_dl = amt_r;
          end
        end
      end
      stp_pkg::ST_SLOT_RMW: begin
        // slot data is back: cancel, extend, or start a release
        rp_next = r_pv; rn_next = r_nx;
        if (act == stp_pkg::ACT_CANCEL && r_fl[2]) begin
          we_fl = 1'b1; w_fl = {1'b1, 1'b0, r_fl[0]};
        end
        if (act == stp_pkg::ACT_EXTEND) begin
          alu_a = r_dl; we_dl = 1'b1; w_dl = alu_sum;
        end
      end
      stp_pkg::ST_ADD_LINK: begin
        // pop the free head and arm the slot in front of the active list
        free_head_next = r_nx;
        we_dl = 1'b1; w_dl = alu_sum;
        we_iv = 1'b1; w_iv = amt_r;
        we_fl = 1'b1; w_fl = {1'b1, 1'b1, rep_r};
        we_nx = 1'b1; w_nx = active_head;
        we_pv = 1'b1; w_pv = NULL_LINK;
      end
      stp_pkg::ST_ADD_ARM: begin
        // back link of the old active head
        if (active_head != NULL_LINK) begin
          maddr = active_head[AW-1:0]; we_pv = 1'b1; w_pv = cur;
        end
        active_head_next = cur;
      end
      stp_pkg::ST_REL_PREV: begin
        if (rp != NULL_LINK) begin
          maddr = rp[AW-1:0]; we_nx = 1'b1; w_nx = rn;
        end
        if (active_head == cur) active_head_next = rn;
      end
      stp_pkg::ST_REL_NEXT: begin
        if (rn != NULL_LINK) begin
          maddr = rn[AW-1:0]; we_pv = 1'b1; w_pv = rp;
        end
      end
      stp_pkg::ST_REL_FREE: begin
        // push on the free list; back links are kept only on the active list
        we_fl = 1'b1; w_fl = '0;
        we_nx = 1'b1; w_nx = free_head;
        we_pv = 1'b1; w_pv = NULL_LINK;
        free_head_next = cur;
        if (act == stp_pkg::ACT_TICK) cur_next = nxt;
      end
      stp_pkg::ST_WALK_EVAL: begin
        // expired check on the visited slot, fire when the output is free; an inactive slot is released
        nxt_next = r_nx; rp_next = r_pv; rn_next = r_nx;
        hit_next = 1'b0;
        if (r_fl[1] && alu_le) begin
          if (out_free) begin
            emit = 1'b1; e_kind = stp_pkg::KIND_FIRED;
            e_slot = 6'(cur); e_last = 1'b0;
            fires_next = fires + 1'b1;
            guard_next = guard + 1'b1;
            hit_next = 1'b1;
          end
        end else begin
          guard_next = guard + 1'b1;
        end
      end
      stp_pkg::ST_WALK_STORE: begin
        // re-arm a repeating slot that fired, fold its deadline into the minimum
        alu_c = mix;
        if (hit) begin
          alu_a = now_r; alu_b = r_iv;
          we_dl = 1'b1; w_dl = alu_sum;
        end else begin
          alu_a = r_dl; alu_b = '0;
        end
        if (alu_lt) mix_next = alu_sum;
        cur_next = nxt;
      end
      stp_pkg::ST_EMIT: begin
        // final result of the request
        if (out_free) begin
          emit = 1'b1;
          if (act == stp_pkg::ACT_ADD) begin
            if (cur == NULL_LINK) begin
              e_kind = stp_pkg::KIND_FULL;
            end else begin
              e_kind = stp_pkg::KIND_ADDED; e_slot = 6'(cur);
            end
          end else if (act == stp_pkg::ACT_TICK) begin
            e_kind = stp_pkg::KIND_DONE; e_nd = mix; e_fc = 4'(fires);
          end
        end
      end
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stp_pkg::ST_CLEAR;
      horizon <= stp_pkg::HORIZON_RESET;
      free_head <= '0;
      active_head <= NULL_LINK;
      clr <= '0;
      fires <= '0;
      ov <= 1'b0;
    end else begin
      state <= state_next;
      free_head <= free_head_next;
      active_head <= active_head_next;
      clr <= clr_next;
      fires <= fires_next;
      if (cfg_we) horizon <= cfg_data;
      if (emit) ov <= 1'b1;
      else if (out_ready) ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next; nxt <= nxt_next; rp <= rp_next; rn <= rn_next;
    mix <= mix_next; guard <= guard_next; hit <= hit_next;
    if (in_fire) begin
      act <= action; now_r <= now_ms; amt_r <= amount_ms;
      rep_r <= repeat_req; slot_r <= slot;
    end
    if (emit) begin
      o_kind <= e_kind; o_slot <= e_slot; o_nd <= e_nd; o_fc <= e_fc; o_last <= e_last;
    end
  end

  a_no_ready_busy: assert property (@(posedge clk) disable iff (rst)
    (state != stp_pkg::ST_IDLE) |-> !in_ready) else $error("ready while busy");
  a_emit_holds: assert property (@(posedge clk) disable iff (rst)
    (ov && !out_ready) |=> ov) else $error("result dropped");
  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    (ov && !out_ready) |=> $stable({o_kind, o_slot, o_nd, o_fc, o_last}))
    else $error("result changed while waiting");
  a_fires_cap: assert property (@(posedge clk) disable iff (rst)
    fires <= FW'(MAX_FIRES)) else $error("fire count over limit");
endmodule
`default_nettype wire

// ----- dv/stp_checker.sv -----
// checker for the software timer pool: watches the request and result channels,
// predicts results with its own timer table, and counts mismatches
// depends on stp_pkg
`timescale 1ns / 1ps
module stp_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [2:0]  action,
  input  wire logic [63:0] now_ms,
  input  wire logic [63:0] amount_ms,
  input  wire logic        repeat_req,
  input  wire logic [5:0]  slot,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [2:0]  kind,
  input  wire logic [5:0]  slot_res,
  input  wire logic [63:0] next_deadline,
  input  wire logic [3:0]  fire_count,
  input  wire logic        last,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_data,
  output int               fail_count,
  output int               pending
);
  localparam int NSLOT = 64;
  localparam int NIL = 64;
  localparam int FIRE_CAP = 10;

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  slot_res;
    logic [63:0] next_deadline;
    logic [3:0]  fire_count;
    logic        last;
  } timer_result_t;

  timer_result_t expected_results[$];

  // shadow timer table
  logic [31:0] horizon;
  logic [63:0] due[NSLOT];
  logic [63:0] period[NSLOT];
  logic        rearm[NSLOT];
  logic        armed[NSLOT];
  logic        in_use[NSLOT];
  int          nxt_of[NSLOT];
  int          prv_of[NSLOT];
  int          free_top;
  int          live_top;

  assign pending = expected_results.size();

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count++;
  endtask

  task automatic push_result(input stp_pkg::kind_t k, input int s, input logic [63:0] nd,
                             input int fc, input logic lst);
    timer_result_t r;
    r.kind = k;
    r.slot_res = s[5:0];
    r.next_deadline = nd;
    r.fire_count = fc[3:0];
    r.last = lst;
    expected_results.push_back(r);
  endtask

  // unlink from the live list and push on the free list
  task automatic free_slot(input int s);
    int p;
    int n;
    p = prv_of[s];
    n = nxt_of[s];
    if (p < NSLOT) nxt_of[p] = n;
    if (n < NSLOT) prv_of[n] = p;
    if (live_top == s) live_top = n;
    armed[s] = 0;
    rearm[s] = 0;
    in_use[s] = 0;
    prv_of[s] = NIL;
    nxt_of[s] = free_top;
    if (free_top < NSLOT) prv_of[free_top] = s;
    free_top = s;
  endtask

  task automatic clear_table();
    horizon = stp_pkg::HORIZON_RESET;
    for (int i = 0; i < NSLOT; i++) begin
      due[i] = '0;
      period[i] = '0;
      rearm[i] = 0;
      armed[i] = 0;
      in_use[i] = 0;
      nxt_of[i] = (i + 1 < NSLOT) ? i + 1 : NIL;
      prv_of[i] = (i == 0) ? NIL : i - 1;
    end
    free_top = 0;
    live_top = NIL;
  endtask

  task automatic predict_request(input logic [2:0] act, input logic [63:0] now,
                                 input logic [63:0] amt, input logic rep, input int s);
    int f;
    int cur;
    int nx;
    int fires;
    int visits;
    logic [63:0] soonest;
    case (act)
      stp_pkg::ACT_ADD: begin
        f = free_top;
        if (f >= NSLOT) begin
          push_result(stp_pkg::KIND_FULL, 0, '0, 0, 1'b1);
        end else begin
          free_top = nxt_of[f];
          if (free_top < NSLOT) prv_of[free_top] = NIL;
          period[f] = amt;
          due[f] = now + amt;
          rearm[f] = rep;
          armed[f] = 1;
          in_use[f] = 1;
          nxt_of[f] = live_top;
          prv_of[f] = NIL;
          if (live_top < NSLOT) prv_of[live_top] = f;
          live_top = f;
          push_result(stp_pkg::KIND_ADDED, f, '0, 0, 1'b1);
        end
      end
      stp_pkg::ACT_TICK: begin
        soonest = now + {32'd0, horizon};
        fires = 0;
        visits = 0;
        cur = live_top;
        while (cur < NSLOT && fires < FIRE_CAP && visits < NSLOT) begin
          nx = nxt_of[cur];
          visits++;
          if (!armed[cur]) begin
            free_slot(cur);
          end else if (due[cur] <= now) begin
            push_result(stp_pkg::KIND_FIRED, cur, '0, 0, 1'b0);
            fires++;
            if (rearm[cur]) begin
              due[cur] = now + period[cur];
              if (due[cur] < soonest) soonest = due[cur];
            end else begin
              free_slot(cur);
            end
          end else if (due[cur] < soonest) begin
            soonest = due[cur];
          end
          cur = nx;
        end
        push_result(stp_pkg::KIND_DONE, 0, soonest, fires, 1'b1);
      end
      default: begin
        case (act)
          stp_pkg::ACT_CANCEL: if (in_use[s]) armed[s] = 0;
          stp_pkg::ACT_REMOVE: if (in_use[s]) free_slot(s);
          stp_pkg::ACT_EXTEND: due[s] = due[s] + amt;
          stp_pkg::ACT_SET:    due[s] = amt;
          default: ;
        endcase
        push_result(stp_pkg::KIND_ACK, 0, '0, 0, 1'b1);
      end
    endcase
  endtask

  // sample both channels after each rising edge
  always @(posedge clk) begin
    timer_result_t want;
    if (rst) begin
      clear_table();
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) horizon = cfg_data;
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d slot %0d", kind, slot_res));
        end else begin
          want = expected_results.pop_front();
          if (kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
          if (slot_res !== want.slot_res)
            report_mismatch($sformatf("slot_res %0d, want %0d", slot_res, want.slot_res));
          if (next_deadline !== want.next_deadline)
            report_mismatch($sformatf("next_deadline %0h, want %0h",
                                      next_deadline, want.next_deadline));
          if (fire_count !== want.fire_count)
            report_mismatch($sformatf("fire_count %0d, want %0d",
                                      fire_count, want.fire_count));
          if (last !== want.last)
            report_mismatch($sformatf("last %0d, want %0d", last, want.last));
        end
      end
      if (in_valid && in_ready)
        predict_request(action, now_ms, amount_ms, repeat_req, int'(slot));
    end
  end
endmodule

// ----- dv/tb_software_timer_pool_top.sv -----
// testbench top for the software timer pool: clock, reset, stimulus and verdict
// depends on stp_pkg, software_timer_pool_top and stp_checker
`timescale 1ns / 1ps
module tb_software_timer_pool_top;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  action;
  logic [63:0] now_ms;
  logic [63:0] amount_ms;
  logic        repeat_req;
  logic [5:0]  slot;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  kind;
  logic [5:0]  slot_res;
  logic [63:0] next_deadline;
  logic [3:0]  fire_count;
  logic        last;
  logic        cfg_we;
  logic [31:0] cfg_data;
  int          fail_count;
  int          pending;

  int          send_idle_pct;
  int          recv_idle_pct;
  bit          hold_off;
  longint      cycle_count;
  logic [63:0] clock_ms;

  localparam longint CYCLE_LIMIT = 400000;

  software_timer_pool_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .now_ms(now_ms), .amount_ms(amount_ms),
    .repeat_req(repeat_req), .slot(slot),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .slot_res(slot_res), .next_deadline(next_deadline),
    .fire_count(fire_count), .last(last),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  stp_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .action(action), .now_ms(now_ms), .amount_ms(amount_ms),
    .repeat_req(repeat_req), .slot(slot),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .slot_res(slot_res), .next_deadline(next_deadline),
    .fire_count(fire_count), .last(last),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  // clock
  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("** software_timer_pool_top: FAILED **");
        $finish;
      end
    end
  end

  // result side: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_off) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_request(input stp_pkg::action_t act, input logic [63:0] now,
                              input logic [63:0] amt, input logic rep, input logic [5:0] s);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    action <= act;
    now_ms <= now;
    amount_ms <= amt;
    repeat_req <= rep;
    slot <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_horizon(input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly timer traffic over a small moving time window, some noise
  task automatic random_requests(input int count);
    int pick;
    logic [63:0] amt;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      clock_ms = clock_ms + $urandom_range(40);
      amt = ($urandom_range(9) == 0) ? {$urandom, $urandom} : 64'($urandom_range(120));
      if (pick < 35)
        send_request(stp_pkg::ACT_ADD, clock_ms, amt, $urandom_range(1), 6'($urandom));
      else if (pick < 60)
        send_request(stp_pkg::ACT_TICK,
                     ($urandom_range(19) == 0) ? {$urandom, $urandom} : clock_ms,
                     {$urandom, $urandom}, $urandom_range(1), 6'($urandom));
      else if (pick < 70)
        send_request(stp_pkg::ACT_CANCEL, {$urandom, $urandom}, amt, $urandom_range(1),
                     6'($urandom));
      else if (pick < 78)
        send_request(stp_pkg::ACT_REMOVE, {$urandom, $urandom}, amt, $urandom_range(1),
                     6'($urandom));
      else if (pick < 86)
        send_request(stp_pkg::ACT_EXTEND, clock_ms, amt, $urandom_range(1), 6'($urandom));
      else if (pick < 95)
        send_request(stp_pkg::ACT_SET, clock_ms, clock_ms + amt, $urandom_range(1),
                     6'($urandom));
      else
        send_request(stp_pkg::action_t'($urandom_range(7)), {$urandom, $urandom},
                     {$urandom, $urandom}, $urandom_range(1), 6'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    action = stp_pkg::ACT_ADD;
    now_ms = '0;
    amount_ms = '0;
    repeat_req = 1'b0;
    slot = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    hold_off = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    clock_ms = 64'd100;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    // clearing pass after reset
    repeat (80) @(posedge clk);

    // directed: extremes, every action, wrap, zero slot, undefined codes
    send_request(stp_pkg::ACT_TICK, '0, '0, 1'b0, '0);
    send_request(stp_pkg::ACT_ADD, 64'd10, 64'd5, 1'b1, '0);
    send_request(stp_pkg::ACT_ADD, '1, 64'd2, 1'b0, '1);
    send_request(stp_pkg::ACT_ADD, 64'd10, '1, 1'b0, '0);
    send_request(stp_pkg::ACT_CANCEL, '0, '0, 1'b0, 6'd2);
    send_request(stp_pkg::ACT_EXTEND, '0, 64'd3, 1'b0, 6'd0);
    send_request(stp_pkg::ACT_SET, '0, 64'd7, 1'b0, 6'd40);
    send_request(stp_pkg::ACT_CANCEL, '0, '0, 1'b0, 6'd50);
    send_request(stp_pkg::ACT_REMOVE, '0, '0, 1'b0, 6'd63);
    send_request(stp_pkg::action_t'(3'd6), '1, '1, 1'b1, '1);
    send_request(stp_pkg::action_t'(3'd7), '0, '0, 1'b0, '0);
    send_request(stp_pkg::ACT_TICK, 64'd20, '0, 1'b0, '0);
    send_request(stp_pkg::ACT_TICK, '1, '1, 1'b1, '1);
    send_request(stp_pkg::ACT_REMOVE, '0, '0, 1'b0, 6'd0);
    send_request(stp_pkg::ACT_TICK, 64'd30, '0, 1'b0, '0);
    drain();
    write_horizon('1);
    write_horizon(32'd0);
    // fill the pool, then overflow, then a tick that hits the fire cap
    for (int i = 0; i < 66; i++)
      send_request(stp_pkg::ACT_ADD, 64'd50, 64'(i % 3), i[0], '0);
    send_request(stp_pkg::ACT_TICK, 64'd60, '0, 1'b0, '0);
    send_request(stp_pkg::ACT_TICK, 64'd60, '0, 1'b0, '0);
    drain();
    write_horizon(32'd1000);

    // random, sender idles more lightly than the receiver
    send_idle_pct = 35;
    recv_idle_pct = 83;
    random_requests(8);
    // long receiver hold-off while requests keep coming
    fork
      begin
        hold_off <= 1'b1;
        repeat (600) @(posedge clk);
        hold_off <= 1'b0;
      end
      random_requests(6);
    join
    drain();
    write_horizon(32'd50);

    send_idle_pct = 83;
    recv_idle_pct = 35;
    random_requests(6);
    drain();
    write_horizon(32'hFFFF_FFFF);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_requests(6);
    drain();

    if (fail_count == 0) begin
      $display("** software_timer_pool_top: PASSED **");
    end else begin
      $display("** software_timer_pool_top: FAILED **");
    end
    $finish;
  end
endmodule
